// File: rtl/sbcs_pkg.sv
// Package for the sprite blitter: sizes, request and result types, register indexes.
`default_nettype none
package sbcs_pkg;

  // Screen and sprite geometry.
  localparam int SCREEN_W    = 320;
  localparam int SPR_W       = 8;
  localparam int SPR_H       = 8;
  localparam int FRAME_COUNT = 16;

  // Every frame holds 64 pattern codes; the sprite uses the first SPR_W*SPR_H.
  localparam int FRAME_SLOTS = 64;
  localparam int PIX_W       = 6;
  localparam int PIX_CNT     = SPR_W * SPR_H;
  localparam int FRAME_AW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int MEM_AW      = FRAME_AW + PIX_W;
  localparam int MEM_DEPTH   = FRAME_COUNT * FRAME_SLOTS;
  localparam int COL_W       = (SPR_W > 1) ? $clog2(SPR_W) : 1;

  // Request commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_SECONDARY = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_TERTIARY  = 1'd1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         frame;
    logic [5:0]         pixel_index;
    logic [7:0]         pattern_value;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         primary_color;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] fb_address;
    logic [7:0]  pixel_color;
    logic        last;
  } out_t;

  // Frame number folded into the store's range of frames.
  function automatic logic [FRAME_AW-1:0] frame_wrap(input logic [3:0] f);
    logic [FRAME_AW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (f == 4'(i)) r = FRAME_AW'(i % FRAME_COUNT);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sprite_blit_color_substitute.sv
// Top level of the transparent sprite blitter with colour substitution.
//
//   Channel  Ports                                Handshake
//   request  start, busy, in_data (in_t)          taken when start high and busy low
//   result   out_strobe, out_data (out_t)         one strobe per result, cannot stall
//   config   cfg_we, cfg_index, cfg_wdata         written when cfg_we high
//
// A load request writes one pattern code in its accept cycle and leaves busy low.
// A draw request forms the base address in the accept cycle, then the run state makes
// one pattern read per cycle, one for each of the SPR_W*SPR_H pixels, from the single
// read port of the pattern store while busy is high. The store data is registered, and
// the address and last flag are registered with it, so results follow on consecutive
// cycles, the last one in the first cycle with busy low.
// Reset (rst_n low, synchronous) clears the sequencer and both colour registers; the
// pattern store is not cleared. The receiver cannot stall the result stream.
`default_nettype none
module sprite_blit_color_substitute (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire sbcs_pkg::in_t in_data,
  output logic               out_strobe,
  output sbcs_pkg::out_t     out_data,
  input  wire logic          cfg_we,
  input  wire logic [sbcs_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [7:0]    cfg_wdata
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam logic [15:0] SCREEN_STEP = 16'(sbcs_pkg::SCREEN_W);
  localparam logic [sbcs_pkg::PIX_W-1:0] LAST_PIX = sbcs_pkg::PIX_W'(sbcs_pkg::PIX_CNT - 1);
  localparam logic [sbcs_pkg::COL_W-1:0] LAST_COL = sbcs_pkg::COL_W'(sbcs_pkg::SPR_W - 1);

  // Sequencer and draw context.
  state_t                        state_r, state_nxt;
  logic [15:0]                   row_addr_r, row_addr_nxt;
  logic [sbcs_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [sbcs_pkg::PIX_W-1:0]    pix_r, pix_nxt;
  logic [sbcs_pkg::FRAME_AW-1:0] frame_r, frame_nxt;
  logic [7:0]                    primary_r, primary_nxt;

  // Result stage, aligned with the registered store read.
  logic        p1_valid_r, p1_valid_nxt;
  logic [15:0] p1_addr_r, p1_addr_nxt;
  logic        p1_last_r, p1_last_nxt;

  logic [7:0] secondary_r, tertiary_r;

  logic [7:0] pat_mem [0:sbcs_pkg::MEM_DEPTH-1];
  logic [7:0] rd_q;

  logic                        accept;
  logic                        mem_we;
  logic [sbcs_pkg::MEM_AW-1:0] mem_waddr;
  logic [sbcs_pkg::MEM_AW-1:0] mem_raddr;
  logic [15:0]                 base_addr;
  logic [15:0]                 pix_addr;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Loads go straight into the store; they are accepted only while idle, so no write
  // lands in the store while a draw is reading it.
  assign mem_we    = accept && (in_data.cmd == sbcs_pkg::CMD_LOAD);
  assign mem_waddr = {sbcs_pkg::frame_wrap(in_data.frame), in_data.pixel_index};
  assign mem_raddr = {frame_r, pix_r};

  // Base address y*SCREEN_W + x, kept modulo 65536 as the frame buffer wraps.
  assign base_addr = 16'($unsigned(in_data.pos_y) * SCREEN_STEP + $unsigned(in_data.pos_x));

  // Address adder of the run loop: start of the current row plus the column.
  assign pix_addr = row_addr_r + 16'(col_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pat_mem[mem_waddr] <= in_data.pattern_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= pat_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secondary_r <= '0;
      tertiary_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbcs_pkg::CFG_SECONDARY: secondary_r <= cfg_wdata;
        sbcs_pkg::CFG_TERTIARY:  tertiary_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    row_addr_nxt = row_addr_r;
    col_nxt      = col_r;
    pix_nxt      = pix_r;
    frame_nxt    = frame_r;
    primary_nxt  = primary_r;
    p1_valid_nxt = 1'b0;
    p1_addr_nxt  = p1_addr_r;
    p1_last_nxt  = p1_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.cmd == sbcs_pkg::CMD_DRAW)) begin
          state_nxt    = ST_RUN;
          row_addr_nxt = base_addr;
          col_nxt      = '0;
          pix_nxt      = '0;
          frame_nxt    = sbcs_pkg::frame_wrap(in_data.frame);
          primary_nxt  = in_data.primary_color;
        end
      end
      ST_RUN: begin
        // The store read for pix_r is issued now; its address and last flag
        // travel one stage to meet the read data.
        p1_valid_nxt = 1'b1;
        p1_addr_nxt  = pix_addr;
        p1_last_nxt  = (pix_r == LAST_PIX);
        pix_nxt      = pix_r + 1'b1;
        if (col_r == LAST_COL) begin
          col_nxt      = '0;
          row_addr_nxt = row_addr_r + SCREEN_STEP;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (pix_r == LAST_PIX) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      p1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p1_valid_r <= p1_valid_nxt;
    end
    row_addr_r <= row_addr_nxt;
    col_r      <= col_nxt;
    pix_r      <= pix_nxt;
    frame_r    <= frame_nxt;
    primary_r  <= primary_nxt;
    p1_addr_r  <= p1_addr_nxt;
    p1_last_r  <= p1_last_nxt;
  end

  // Code 0 is transparent and gives colour 0; codes 1 to 3 pick a palette colour, and higher codes pass through.
  logic [7:0] sub_color;
  always_comb begin
    case (rd_q)
      8'd1:    sub_color = secondary_r;
      8'd2:    sub_color = primary_r;
      8'd3:    sub_color = tertiary_r;
      default: sub_color = rd_q;
    endcase
  end

  assign out_strobe            = p1_valid_r;
  assign out_data.write_enable = (rd_q != 8'd0);
  assign out_data.fb_address   = p1_addr_r;
  assign out_data.pixel_color  = sub_color;
  assign out_data.last         = p1_last_r;

endmodule
`default_nettype wire

// File: rtl/sbcs_checker.sv
// Port-level checker for the sprite blitter, bound to the top level.
`default_nettype none
module sbcs_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire sbcs_pkg::in_t in_data,
  input wire logic          out_strobe,
  input wire sbcs_pkg::out_t out_data
);

  // A draw request keeps the block busy in the next cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd == sbcs_pkg::CMD_DRAW) |=> busy)
    else $error("draw request did not make the block busy");

  // A load request produces no result and leaves the block free.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd == sbcs_pkg::CMD_LOAD) |=> !busy && !out_strobe)
    else $error("load request produced a result or kept the block busy");

  // The results of one sprite come without gaps until the last one.
  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last |=> out_strobe)
    else $error("gap in the result stream of a sprite");

  // The last result is never followed at once by another.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last |=> !out_strobe)
    else $error("result directly after the last pixel of a sprite");

  // A transparent pixel carries colour zero.
  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.write_enable |-> (out_data.pixel_color == 8'd0))
    else $error("transparent pixel with a non-zero colour");

endmodule

bind sprite_blit_color_substitute sbcs_checker u_sbcs_checker (.*);
`default_nettype wire
